// File: src/vegetation_index_pixel_assert.svh
// Assertion macros shared by the vegetation index RTL.
`ifndef VEGETATION_INDEX_PIXEL_ASSERT_SVH
`define VEGETATION_INDEX_PIXEL_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define VIP_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define VIP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/vip_pkg.sv
// Types, constants and the divider step function of the vegetation index block.
package vip_pkg;

    localparam int SAMPLE_W  = 16;
    localparam int CNT_W     = SAMPLE_W + 2;
    localparam int VAL_W     = 24;
    localparam int MAG_W     = 23;
    localparam int QUO_W     = 17;
    localparam int DIV_STEPS = QUO_W;
    localparam int OUT_W     = 15;
    localparam int ADDR_W    = 5;

    localparam logic signed [OUT_W-1:0] VI_UNDEF = -15'sd9999;
    localparam logic [QUO_W-1:0] Q_MAX_POS = 17'd72090;
    localparam logic [QUO_W-1:0] Q_MAX_NEG = 17'd6554;

    localparam logic [2:0] REG_FILL    = 3'd0;
    localparam logic [2:0] REG_SIGNED  = 3'd1;
    localparam logic [2:0] REG_OFFSET  = 3'd2;
    localparam logic [2:0] REG_CPU     = 3'd3;
    localparam logic [2:0] REG_NDVI_EN = 3'd4;
    localparam logic [2:0] REG_EVI_EN  = 3'd5;

    typedef struct packed {
        logic [MAG_W-1:0] rem;
        logic             nb;
        logic [MAG_W-1:0] den;
        logic [QUO_W-1:0] quo;
        logic             neg;
        logic             sat;
        logic             undef;
    } t_div;

    // One restoring step: shift in the next dividend bit, subtract if it fits.
    function automatic t_div div_step(t_div x);
        t_div          y;
        logic [MAG_W:0]   t;
        logic [MAG_W+1:0] diff;
        y    = x;
        t    = {x.rem, x.nb};
        diff = {1'b0, t} - {2'b00, x.den};
        y.nb = 1'b0;
        if (!diff[MAG_W+1]) begin
            y.rem = diff[MAG_W-1:0];
            y.quo = {x.quo[QUO_W-2:0], 1'b1};
        end else begin
            y.rem = t[MAG_W-1:0];
            y.quo = {x.quo[QUO_W-2:0], 1'b0};
        end
        return y;
    endfunction

endpackage

// File: src/vegetation_index_pixel.sv
// Top level of the pipelined NDVI and EVI per-pixel vegetation index block.
//
//  channel   dir  handshake                 word
//  pixels    in   i_s_tvalid / o_s_tready   blue, red, nir samples
//  indices   out  o_m_tvalid / i_m_tready   ndvi_value, evi_value
//  config    in   psel/penable/pwrite       six registers, APB style
//
// A pixel is accepted every cycle while the output side keeps up. The
// pipeline is formed by the two 17-step restoring dividers (one quotient
// bit per stage) plus five stages of sample conversion, numerator and
// denominator forming, magnitude taking, clamping with scaling by 10000,
// and rounding. Reset is synchronous and clears only the valid bits and
// configuration. When the output word is not taken the whole pipeline
// holds, so nothing is lost or repeated.
module vegetation_index_pixel (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    // [15:0] blue_sample, [31:16] red_sample, [47:32] nir_sample
    input  logic [47:0]                   i_s_tdata,
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    // [14:0] ndvi_value, [29:15] evi_value, [31:30] zero
    output logic [31:0]                   o_m_tdata,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [vip_pkg::ADDR_W-1:0]    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    import vip_pkg::*;

    `include "vegetation_index_pixel_assert.svh"

    // Configuration registers.
    logic [15:0]        r_fill;
    logic               r_signed;
    logic signed [15:0] r_offset;
    logic [15:0]        r_cpu;
    logic               r_ndvi_en;
    logic               r_evi_en;
    logic [2:0]         cfg_idx;
    logic               cfg_wr;

    assign pready  = 1'b1;
    assign cfg_idx = paddr[ADDR_W-1:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill    <= 16'd32767;
            r_signed  <= 1'b1;
            r_offset  <= 16'sd0;
            r_cpu     <= 16'd10000;
            r_ndvi_en <= 1'b1;
            r_evi_en  <= 1'b1;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_FILL:    r_fill    <= pwdata[15:0];
                REG_SIGNED:  r_signed  <= pwdata[0];
                REG_OFFSET:  r_offset  <= pwdata[15:0];
                REG_CPU:     r_cpu     <= pwdata[15:0];
                REG_NDVI_EN: r_ndvi_en <= pwdata[0];
                REG_EVI_EN:  r_evi_en  <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            REG_FILL:    prdata = {16'd0, r_fill};
            REG_SIGNED:  prdata = {31'd0, r_signed};
            REG_OFFSET:  prdata = {16'd0, r_offset};
            REG_CPU:     prdata = {16'd0, r_cpu};
            REG_NDVI_EN: prdata = {31'd0, r_ndvi_en};
            REG_EVI_EN:  prdata = {31'd0, r_evi_en};
            default:     prdata = 32'd0;
        endcase
    end

    // The whole pipeline moves together whenever the output register is free.
    logic adv;
    assign adv        = !o_m_tvalid || i_m_tready;
    assign o_s_tready = adv;

    // Stage 1: samples converted to counts, fill codes detected on raw bits.
    logic                    r_v1;
    logic signed [CNT_W-1:0] r_b, r_r, r_n;
    logic                    r_bf, r_rf, r_nf;

    function automatic logic signed [CNT_W-1:0] to_counts(logic [SAMPLE_W-1:0] raw,
                                                          logic sgn,
                                                          logic signed [15:0] off);
        logic signed [CNT_W-1:0] v;
        v = sgn ? CNT_W'($signed(raw)) : CNT_W'(raw);
        return v - CNT_W'(off);
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (adv) begin
            r_v1 <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_b  <= to_counts(i_s_tdata[SAMPLE_W-1:0], r_signed, r_offset);
            r_r  <= to_counts(i_s_tdata[16 +: SAMPLE_W], r_signed, r_offset);
            r_n  <= to_counts(i_s_tdata[32 +: SAMPLE_W], r_signed, r_offset);
            r_bf <= i_s_tdata[SAMPLE_W-1:0] == r_fill[SAMPLE_W-1:0];
            r_rf <= i_s_tdata[16 +: SAMPLE_W] == r_fill[SAMPLE_W-1:0];
            r_nf <= i_s_tdata[32 +: SAMPLE_W] == r_fill[SAMPLE_W-1:0];
        end
    end

    // Stage 2: numerators and denominators. EVI is taken as
    // 5(n-r)/(2C+2n+12r-15b); the soil-adjusted fallback as 3(n-r)/(C+2n+2r).
    logic                    r_v2;
    logic signed [VAL_W-1:0] r_nd_num, r_nd_den, r_ev_num, r_ev_den;
    logic                    r_nd_off, r_ev_off;

    logic signed [VAL_W-1:0] b_x, r_x, n_x, c_x, d_x;
    logic                    use_evi;
    assign b_x     = VAL_W'(r_b);
    assign r_x     = VAL_W'(r_r);
    assign n_x     = VAL_W'(r_n);
    assign c_x     = VAL_W'($signed({1'b0, r_cpu}));
    assign d_x     = n_x - r_x;
    assign use_evi = !r_bf && ((r_b <= r_r) || (r_r <= r_n));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (adv) begin
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_nd_num <= d_x;
            r_nd_den <= n_x + r_x;
            r_nd_off <= !r_ndvi_en || r_rf || r_nf;
            r_ev_off <= !r_evi_en || r_rf || r_nf;
            if (use_evi) begin
                r_ev_num <= (d_x <<< 2) + d_x;
                r_ev_den <= (c_x <<< 1) + (n_x <<< 1) + (r_x <<< 3) + (r_x <<< 2)
                          - ((b_x <<< 4) - b_x);
            end else begin
                r_ev_num <= (d_x <<< 1) + d_x;
                r_ev_den <= c_x + (n_x <<< 1) + (r_x <<< 1);
            end
        end
    end

    // Stage 3: magnitudes, quotient sign and saturation. The quotient
    // |num|*2^16/|den| needs at most 17 bits unless |num| >= 2|den|, which
    // clamps anyway, so the divider only runs the low 17 quotient bits.
    function automatic t_div div_entry(logic signed [VAL_W-1:0] num,
                                       logic signed [VAL_W-1:0] den,
                                       logic off);
        t_div                 e;
        logic [MAG_W-1:0]     a;
        logic [MAG_W-1:0]     b;
        a         = num[VAL_W-1] ? MAG_W'(-num) : MAG_W'(num);
        b         = den[VAL_W-1] ? MAG_W'(-den) : MAG_W'(den);
        e.rem     = a >> 1;
        e.nb      = a[0];
        e.den     = b;
        e.quo     = '0;
        e.neg     = num[VAL_W-1] ^ den[VAL_W-1];
        e.sat     = {1'b0, a} >= {b, 1'b0};
        e.undef   = off || (den == '0);
        return e;
    endfunction

    logic r_vd [0:DIV_STEPS];
    t_div r_dn [0:DIV_STEPS];
    t_div r_de [0:DIV_STEPS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= DIV_STEPS; k++) begin
                r_vd[k] <= 1'b0;
            end
        end else if (adv) begin
            r_vd[0] <= r_v2;
            for (int k = 1; k <= DIV_STEPS; k++) begin
                r_vd[k] <= r_vd[k-1];
            end
        end
    end

    // Stages 4 to 20: one quotient bit per stage in each lane.
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_dn[0] <= div_entry(r_nd_num, r_nd_den, r_nd_off);
            r_de[0] <= div_entry(r_ev_num, r_ev_den, r_ev_off);
            for (int k = 1; k <= DIV_STEPS; k++) begin
                r_dn[k] <= div_step(r_dn[k-1]);
                r_de[k] <= div_step(r_de[k-1]);
            end
        end
    end

    // Stage 21: clamp to -0.1..1.1 in Q16 and scale by 10000.
    function automatic logic signed [31:0] clamp_scale(t_div x);
        logic [QUO_W-1:0]  m;
        logic signed [31:0] q;
        if (x.neg) begin
            m = (x.sat || x.quo > Q_MAX_NEG) ? Q_MAX_NEG : x.quo;
            q = -$signed({15'd0, m});
        end else begin
            m = (x.sat || x.quo > Q_MAX_POS) ? Q_MAX_POS : x.quo;
            q = $signed({15'd0, m});
        end
        return q * 32'sd10000;
    endfunction

    logic               r_vm;
    logic signed [31:0] r_nd_p, r_ev_p;
    logic               r_nd_u, r_ev_u;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vm <= 1'b0;
        end else if (adv) begin
            r_vm <= r_vd[DIV_STEPS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_nd_p <= clamp_scale(r_dn[DIV_STEPS]);
            r_ev_p <= clamp_scale(r_de[DIV_STEPS]);
            r_nd_u <= r_dn[DIV_STEPS].undef;
            r_ev_u <= r_de[DIV_STEPS].undef;
        end
    end

    // Stage 22: add one half and truncate toward zero, or mark undefined.
    function automatic logic signed [OUT_W-1:0] round_out(logic signed [31:0] p,
                                                          logic u);
        logic signed [32:0] x;
        logic signed [32:0] y;
        x = 33'(p) + 33'sd32768;
        if (x < 0) begin
            y = -((-x) >>> 16);
        end else begin
            y = x >>> 16;
        end
        return u ? VI_UNDEF : y[OUT_W-1:0];
    endfunction

    logic                    r_vo;
    logic signed [OUT_W-1:0] r_ndvi, r_evi;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vo <= 1'b0;
        end else if (adv) begin
            r_vo <= r_vm;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_ndvi <= round_out(r_nd_p, r_nd_u);
            r_evi  <= round_out(r_ev_p, r_ev_u);
        end
    end

    assign o_m_tvalid = r_vo;
    assign o_m_tdata  = {2'b00, r_evi, r_ndvi};

    // The input side only waits on a result that is held back.
    `VIP_ASSERT_NOW(a_ready_only_on_stall, !o_s_tready, o_m_tvalid && !i_m_tready, "bad stall")
    `VIP_ASSERT_NOW(a_ndvi_range, o_m_tvalid, r_ndvi >= VI_UNDEF && r_ndvi <= 11000, "ndvi range")
    `VIP_ASSERT_NOW(a_evi_range, o_m_tvalid, r_evi >= VI_UNDEF && r_evi <= 11000, "evi range")
    `VIP_ASSERT_NEXT(a_nd_hold, r_v2 && !adv, r_v2 && $stable(r_nd_den), "ndvi stage moved")
    `VIP_ASSERT_NEXT(a_ev_hold, r_v2 && !adv, r_v2 && $stable(r_ev_den), "evi stage moved")

endmodule

// File: tb/testbench.sv
// Self-checking testbench for the vegetation index pixel block.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import vip_pkg::*;

    localparam int LIMIT_CYCLES = 400000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_tvalid;
    logic        o_s_tready;
    // [15:0] blue_sample, [31:16] red_sample, [47:32] nir_sample
    logic [47:0] i_s_tdata;
    logic        o_m_tvalid;
    logic        i_m_tready;
    // [14:0] ndvi_value, [29:15] evi_value, [31:30] zero
    logic [31:0] o_m_tdata;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    typedef struct packed {
        logic [14:0] ndvi;
        logic [14:0] evi;
    } t_indices;

    // Shadow copy of the configuration registers.
    logic [15:0] fill_code;
    logic        signed_samples;
    logic [15:0] offset_code;
    logic [15:0] unit_counts;
    logic        ndvi_on;
    logic        evi_on;

    t_indices    pending_indices[$];
    int          error_count;
    int          cycle_count;
    int          send_idle_pct;
    int          recv_stall_pct;

    vegetation_index_pixel DUT (.*);

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Raw sample to count value after sign reading and offset removal.
    function automatic longint sample_counts(logic [15:0] raw);
        longint v;
        longint off;
        v = signed_samples ? longint'($signed(raw)) : longint'(raw);
        off = longint'($signed(offset_code));
        return v - off;
    endfunction

    function automatic logic [14:0] scaled_quotient(longint num, longint den);
        longint q;
        longint s;
        q = (num * 65536) / den;
        if (q < -6554) q = -6554;
        if (q > 72090) q = 72090;
        s = (q * 10000 + 32768) / 65536;
        return s[14:0];
    endfunction

    function automatic t_indices predict_indices(logic [47:0] word);
        t_indices res;
        logic bf, rf, nf;
        longint b, r, n, c, den;
        bf = word[15:0] == fill_code;
        rf = word[31:16] == fill_code;
        nf = word[47:32] == fill_code;
        b = sample_counts(word[15:0]);
        r = sample_counts(word[31:16]);
        n = sample_counts(word[47:32]);
        c = longint'(unit_counts);
        res.ndvi = VI_UNDEF;
        res.evi = VI_UNDEF;
        if (ndvi_on && !rf && !nf && (n + r) != 0)
            res.ndvi = scaled_quotient(n - r, n + r);
        if (evi_on && !rf && !nf) begin
            if (!bf && (b <= r || r <= n)) begin
                den = 2 * c + 2 * n + 12 * r - 15 * b;
                if (den != 0) res.evi = scaled_quotient(5 * (n - r), den);
            end else begin
                den = c + 2 * n + 2 * r;
                if (den != 0) res.evi = scaled_quotient(3 * (n - r), den);
            end
        end
        return res;
    endfunction

    // Timeout watchdog.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("vegetation_index_pixel verification failed");
            $finish;
        end
    end

    // Receiver: random stalls, and each accepted word is checked.
    always @(posedge i_clk) begin
        t_indices got;
        t_indices want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got.ndvi = o_m_tdata[14:0];
            got.evi = o_m_tdata[29:15];
            if (pending_indices.size() == 0) begin
                $error("unexpected result word %h", o_m_tdata);
                error_count++;
            end else begin
                want = pending_indices.pop_front();
                if (got.ndvi !== want.ndvi) begin
                    $error("ndvi_value expected %0d got %0d",
                           $signed(want.ndvi), $signed(got.ndvi));
                    error_count++;
                end
                if (got.evi !== want.evi) begin
                    $error("evi_value expected %0d got %0d",
                           $signed(want.evi), $signed(got.evi));
                    error_count++;
                end
                if (o_m_tdata[31:30] !== 2'b00) begin
                    $error("padding expected 0 got %b", o_m_tdata[31:30]);
                    error_count++;
                end
            end
        end
        i_m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Valid stays high from one word to the next unless the sender idles.
    task automatic send_pixel(logic [15:0] blue, logic [15:0] red, logic [15:0] nir);
        while ($urandom_range(99) < send_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata <= {nir, red, blue};
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        pending_indices.push_back(predict_indices({nir, red, blue}));
    endtask

    task automatic wait_drained();
        i_s_tvalid <= 1'b0;
        while (pending_indices.size() != 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);
    endtask

    // Leaves the bus in the access phase; set_config releases it afterwards.
    task automatic write_register(logic [2:0] index, logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ADDR_W'(index) << 2;
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        case (index)
            REG_FILL:    fill_code = value[15:0];
            REG_SIGNED:  signed_samples = value[0];
            REG_OFFSET:  offset_code = value[15:0];
            REG_CPU:     unit_counts = value[15:0];
            REG_NDVI_EN: ndvi_on = value[0];
            REG_EVI_EN:  evi_on = value[0];
            default: ;
        endcase
    endtask

    task automatic set_config(logic [15:0] fill, logic sgn, logic [15:0] off,
                              logic [15:0] cpu, logic nd, logic ev);
        wait_drained();
        write_register(REG_FILL, {16'h0, fill});
        write_register(REG_SIGNED, {31'h0, sgn});
        write_register(REG_OFFSET, {16'h0, off});
        write_register(REG_CPU, {16'h0, cpu});
        write_register(REG_NDVI_EN, {31'h0, nd});
        write_register(REG_EVI_EN, {31'h0, ev});
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // Samples drawn near fill, zero, extremes, or at random, to hit special cases.
    function automatic logic [15:0] pick_sample();
        case ($urandom_range(9))
            0: return fill_code;
            1: return 16'h0000;
            2: return 16'hFFFF;
            3: return 16'h8000;
            4: return 16'h7FFF;
            5, 6: return offset_code + 16'($urandom_range(3000));
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic test_directed();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        send_pixel(16'd500, 16'd800, 16'd4000);
        send_pixel(16'd0, 16'd0, 16'd0);            // zero sum for NDVI
        send_pixel(16'h7FFF, 16'd800, 16'd4000);    // blue is fill: SAVI
        send_pixel(16'd500, 16'h7FFF, 16'd4000);    // red is fill
        send_pixel(16'd500, 16'd800, 16'h7FFF);     // nir is fill
        send_pixel(16'd3000, 16'd2000, 16'd1000);   // blue above red above nir
        send_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_pixel(16'h8000, 16'h8000, 16'h7FFE);
        send_pixel(16'h0000, 16'd10000, 16'h0000);  // clamps low
        send_pixel(16'h0000, 16'h0000, 16'd10000);  // clamps high
        send_pixel(16'd1334, 16'd0, 16'd5);         // EVI denominator zero
        send_pixel(16'hAAAA, 16'h5555, 16'hAAAA);
        send_pixel(16'h5555, 16'hAAAA, 16'h5555);
        send_pixel(16'd100, 16'h8001, 16'h7FF0);
    endtask

    task automatic test_random_phase(int count, int idle, int stall);
        send_idle_pct = idle;
        recv_stall_pct = stall;
        repeat (count) send_pixel(pick_sample(), pick_sample(), pick_sample());
    endtask

    task automatic test_settings();
        set_config(16'h0000, 1'b0, 16'h0000, 16'd1, 1'b1, 1'b1);
        test_random_phase(250, 46, 0);
        set_config(16'hFFFF, 1'b1, 16'h8000, 16'hFFFF, 1'b0, 1'b1);
        test_random_phase(250, 0, 46);
        set_config(16'h1234, 1'b0, 16'h7FFF, 16'd0, 1'b1, 1'b0);
        test_random_phase(200, 7, 7);
        set_config(16'h7FFF, 1'b1, 16'hFC18, 16'd10000, 1'b1, 1'b1);
        test_random_phase(250, 46, 46);
        // Zero counts make the SAVI denominator zero when n+r is zero.
        set_config(16'h7FFF, 1'b1, 16'h0000, 16'd0, 1'b1, 1'b1);
        send_idle_pct = 0;
        send_pixel(16'h7FFF, 16'd0, 16'd0);
        test_random_phase(200, 0, 0);
        set_config(16'hFFFF, 1'b0, 16'h0000, 16'd4096, 1'b0, 1'b0);
        test_random_phase(100, 7, 7);
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tdata = '0;
        i_m_tready = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        error_count = 0;
        cycle_count = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        fill_code = 16'd32767;
        signed_samples = 1'b1;
        offset_code = 16'h0000;
        unit_counts = 16'd10000;
        ndvi_on = 1'b1;
        evi_on = 1'b1;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_random_phase(500, 0, 0);
        test_settings();

        wait_drained();
        if (error_count == 0) begin
            $display("vegetation_index_pixel verification clean");
        end else begin
            $display("vegetation_index_pixel verification failed");
        end
        $finish;
    end
endmodule

// File: filelist.f
+incdir+src
src/vip_pkg.sv
src/vegetation_index_pixel.sv
tb/testbench.sv
